// ----- rtl/urb_pkg.sv -----
// Shared types and constants for the UART transmit/receive ring buffer block.
// No dependencies; imported by urb_ctrl, urb_datapath, the top level and the testbench.
`default_nettype none

package urb_pkg;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int BLEN_W  = 9;
    localparam int LIMIT_W = 7;
    localparam int ST_W    = 2;

    // Default sizing
    localparam int URB_DEPTH_DEF    = 512;
    localparam int URB_MAX_READ_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_RX    = 2'd2;
    localparam logic [OP_W-1:0] OP_SENT  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOINIT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    // What the result register loads
    typedef enum logic [1:0] {
        EM_NONE,
        EM_STATUS,
        EM_READ,
        EM_TX
    } urb_emit_t;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        logic      exec;
        logic      rd_issue;
        logic      tx_issue;
        urb_emit_t emit;
    } urb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            enabled;
        logic            tx_needed;
        logic            rd_more;
        logic            rd_last;
    } urb_stat_t;

endpackage

`default_nettype wire

// ----- rtl/urb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/urb_ctrl.sv -----
// Sequencer for the ring buffer block: steps each item through execute,
// memory read and result cycles. Depends on urb_pkg.
`default_nettype none

module urb_ctrl
    import urb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire urb_stat_t stat,
    output urb_cmd_t       cmd,
    output logic           busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TX_RD,
        S_TX_OUT,
        S_RD_ISSUE,
        S_RD_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.tx_issue = 1'b0;
        cmd.emit     = EM_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.tx_needed)
                begin
                    state_next = S_TX_RD;
                end
                else if (stat.op == OP_READ && stat.enabled)
                begin
                    state_next = S_RD_ISSUE;
                end
                else
                begin
                    cmd.emit   = EM_STATUS;
                    state_next = S_IDLE;
                end
            end
            S_TX_RD:
            begin
                cmd.tx_issue = 1'b1;
                state_next   = S_TX_OUT;
            end
            S_TX_OUT:
            begin
                cmd.emit   = EM_TX;
                state_next = S_IDLE;
            end
            S_RD_ISSUE:
            begin
                if (stat.rd_more)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RD_OUT;
                end
                else
                begin
                    // nothing to drain: one empty result
                    cmd.emit   = EM_STATUS;
                    state_next = S_IDLE;
                end
            end
            S_RD_OUT:
            begin
                cmd.emit   = EM_READ;
                state_next = stat.rd_last ? S_IDLE : S_RD_ISSUE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- rtl/urb_datapath.sv -----
// Datapath: ring pointers, burst bookkeeping, both byte rings and the result
// register. Depends on urb_pkg and urb_ram.
`default_nettype none

module urb_datapath
    import urb_pkg::*;
#(
    parameter int DEPTH    = URB_DEPTH_DEF,
    parameter int MAX_READ = URB_MAX_READ_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire urb_cmd_t           cmd,
    output urb_stat_t               stat,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic [BLEN_W-1:0]  burst_length,
    input  wire logic               burst_last,
    input  wire logic [LIMIT_W-1:0] read_limit,
    output logic                    result_valid,
    output logic [ST_W-1:0]         status,
    output logic [BYTE_W-1:0]       read_byte,
    output logic                    read_valid,
    output logic                    last,
    output logic                    tx_start,
    output logic [BYTE_W-1:0]       tx_byte,
    output logic                    overflow_seen
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int LW = (CW > BLEN_W) ? CW : BLEN_W;

    function automatic logic [AW-1:0] nxt_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    // Captured item
    logic [OP_W-1:0]    op_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [BLEN_W-1:0]  blen_reg;
    logic               blast_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Port state
    logic               en_reg,    en_next;
    logic [AW-1:0]      srd_reg,   srd_next;
    logic [AW-1:0]      swr_reg,   swr_next;
    logic [AW-1:0]      rrd_reg,   rrd_next;
    logic [AW-1:0]      rwr_reg,   rwr_next;
    logic               lb_reg,    lb_next;
    logic               ovf_reg,   ovf_next;
    logic               bopen_reg, bopen_next;
    logic               brej_reg,  brej_next;
    logic [BLEN_W-1:0]  brem_reg,  brem_next;
    logic [LIMIT_W-1:0] cnt_reg,   cnt_next;
    logic               rdl_reg,   rdl_next;

    // Result register
    logic               rv_reg;
    logic [ST_W-1:0]    st_reg;
    logic [BYTE_W-1:0]  rb_reg;
    logic               rbv_reg;
    logic               last_reg;
    logic               ts_reg;
    logic [BYTE_W-1:0]  tb_reg;
    logic               ovs_reg;

    // Work signals
    logic [CW-1:0]      used;
    logic [CW-1:0]      free_sp;
    logic               rej;
    logic [BLEN_W-1:0]  rem;
    logic [BLEN_W-1:0]  rem_after;
    logic [AW-1:0]      swr_adv;
    logic [AW-1:0]      srd_adv;
    logic               tx_needed;
    logic [ST_W-1:0]    status_calc;
    logic               tx_we;
    logic               rx_we;
    logic [LIMIT_W-1:0] rd_n;
    logic [LIMIT_W-1:0] cnt_inc;
    logic [BYTE_W-1:0]  tx_q;
    logic [BYTE_W-1:0]  rx_q;

    // Free space in the transmit ring
    always_comb
    begin
        if (swr_reg >= srd_reg)
        begin
            used = CW'(swr_reg) - CW'(srd_reg);
        end
        else
        begin
            used = CW'(DEPTH) - (CW'(srd_reg) - CW'(swr_reg));
        end
        free_sp = CW'(DEPTH - 1) - used;
    end

    // Read drain bound and progress
    function automatic logic [LIMIT_W-1:0] read_limit_clip(input logic [LIMIT_W-1:0] l);
        return (l > LIMIT_W'(MAX_READ)) ? LIMIT_W'(MAX_READ) : l;
    endfunction

    assign rd_n    = (read_limit_clip(limit_reg));
    assign cnt_inc = cnt_reg + 1'b1;

    // Per-item state update
    always_comb
    begin
        en_next     = en_reg;
        srd_next    = srd_reg;
        swr_next    = swr_reg;
        rrd_next    = rrd_reg;
        rwr_next    = rwr_reg;
        lb_next     = lb_reg;
        ovf_next    = ovf_reg;
        bopen_next  = bopen_reg;
        brej_next   = brej_reg;
        brem_next   = brem_reg;
        cnt_next    = cnt_reg;
        rdl_next    = rdl_reg;
        rej         = brej_reg;
        rem         = brem_reg;
        rem_after   = brem_reg;
        swr_adv     = swr_reg;
        srd_adv     = srd_reg;
        tx_needed   = 1'b0;
        tx_we       = 1'b0;
        rx_we       = 1'b0;
        status_calc = en_reg ? ST_OK : ST_NOINIT;

        if (cmd.capture)
        begin
            cnt_next = '0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_WRITE:
                begin
                    // burst admission decided at its first byte
                    if (!bopen_reg)
                    begin
                        rej = !en_reg || (LW'(blen_reg) > LW'(free_sp));
                        rem = rej ? '0 : blen_reg;
                    end
                    rem_after = rem;
                    if (rej)
                    begin
                        status_calc = en_reg ? ST_FULL : ST_NOINIT;
                    end
                    else
                    begin
                        status_calc = ST_OK;
                        if (rem != '0)
                        begin
                            tx_we     = 1'b1;
                            swr_adv   = nxt_ptr(swr_reg);
                            rem_after = rem - 1'b1;
                        end
                    end
                    swr_next  = swr_adv;
                    tx_needed = !rej && blast_reg && !lb_reg && (srd_reg != swr_adv);
                    if (tx_needed)
                    begin
                        lb_next = 1'b1;
                    end
                    if (blast_reg)
                    begin
                        bopen_next = 1'b0;
                        brej_next  = 1'b0;
                        brem_next  = '0;
                    end
                    else
                    begin
                        bopen_next = 1'b1;
                        brej_next  = rej;
                        brem_next  = rem_after;
                    end
                end
                OP_RX:
                begin
                    if (en_reg)
                    begin
                        if (nxt_ptr(rwr_reg) == rrd_reg)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            rx_we    = 1'b1;
                            rwr_next = nxt_ptr(rwr_reg);
                        end
                    end
                end
                OP_SENT:
                begin
                    // retire head byte, hand over the next one
                    if (en_reg && lb_reg)
                    begin
                        if (srd_reg != swr_reg)
                        begin
                            srd_adv = nxt_ptr(srd_reg);
                        end
                        srd_next = srd_adv;
                        if (srd_adv != swr_reg)
                        begin
                            tx_needed = 1'b1;
                        end
                        else
                        begin
                            lb_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // host read: drained in later cycles
                end
            endcase
        end

        // Receive drain step
        if (cmd.rd_issue)
        begin
            rrd_next = nxt_ptr(rrd_reg);
            cnt_next = cnt_inc;
            rdl_next = !((cnt_inc < rd_n) && (nxt_ptr(rrd_reg) != rwr_reg));
        end

        // Register write empties both rings
        if (cfg_we)
        begin
            en_next    = cfg_data;
            srd_next   = '0;
            swr_next   = '0;
            rrd_next   = '0;
            rwr_next   = '0;
            lb_next    = 1'b0;
            ovf_next   = 1'b0;
            bopen_next = 1'b0;
            brej_next  = 1'b0;
            brem_next  = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            srd_reg   <= '0;
            swr_reg   <= '0;
            rrd_reg   <= '0;
            rwr_reg   <= '0;
            lb_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
            bopen_reg <= 1'b0;
            brej_reg  <= 1'b0;
            brem_reg  <= '0;
            cnt_reg   <= '0;
            rdl_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            en_reg    <= en_next;
            srd_reg   <= srd_next;
            swr_reg   <= swr_next;
            rrd_reg   <= rrd_next;
            rwr_reg   <= rwr_next;
            lb_reg    <= lb_next;
            ovf_reg   <= ovf_next;
            bopen_reg <= bopen_next;
            brej_reg  <= brej_next;
            brem_reg  <= brem_next;
            cnt_reg   <= cnt_next;
            rdl_reg   <= rdl_next;
            rv_reg    <= (cmd.emit != EM_NONE);
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            data_reg  <= data_byte;
            blen_reg  <= burst_length;
            blast_reg <= burst_last;
            limit_reg <= read_limit;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            EM_STATUS:
            begin
                st_reg   <= status_calc;
                rb_reg   <= '0;
                rbv_reg  <= 1'b0;
                last_reg <= 1'b1;
                ts_reg   <= 1'b0;
                tb_reg   <= '0;
                ovs_reg  <= ovf_next;
            end
            EM_READ:
            begin
                st_reg   <= ST_OK;
                rb_reg   <= rx_q;
                rbv_reg  <= 1'b1;
                last_reg <= rdl_reg;
                ts_reg   <= 1'b0;
                tb_reg   <= '0;
                ovs_reg  <= ovf_reg;
            end
            EM_TX:
            begin
                st_reg   <= ST_OK;
                rb_reg   <= '0;
                rbv_reg  <= 1'b0;
                last_reg <= 1'b1;
                ts_reg   <= 1'b1;
                tb_reg   <= tx_q;
                ovs_reg  <= ovf_reg;
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

    // Transmit ring
    urb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (swr_reg),
        .wdata (data_reg),
        .re    (cmd.tx_issue),
        .raddr (srd_reg),
        .rdata (tx_q)
    );

    // Receive ring
    urb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rwr_reg),
        .wdata (data_reg),
        .re    (cmd.rd_issue),
        .raddr (rrd_reg),
        .rdata (rx_q)
    );

    // Status to the sequencer
    assign stat.op        = op_reg;
    assign stat.enabled   = en_reg;
    assign stat.tx_needed = tx_needed;
    assign stat.rd_more   = (cnt_reg < rd_n) && (rrd_reg != rwr_reg);
    assign stat.rd_last   = rdl_reg;

    assign result_valid  = rv_reg;
    assign status        = st_reg;
    assign read_byte     = rb_reg;
    assign read_valid    = rbv_reg;
    assign last          = last_reg;
    assign tx_start      = ts_reg;
    assign tx_byte       = tb_reg;
    assign overflow_seen = ovs_reg;

endmodule

`default_nettype wire

// ----- rtl/uart_tx_rx_ring_buffers.sv -----
// Top level of the UART transmit/receive ring buffer block.
// Depends on urb_pkg, urb_ctrl, urb_datapath (which holds two urb_ram).
//
// Channel   Handshake               Payload
// item      start, busy             operation, data_byte, burst_length,
//                                   burst_last, read_limit
// result    result_valid (strobe)   status, read_byte, read_valid, last,
//                                   tx_start, tx_byte, overflow_seen
// config    cfg_valid, cfg_ready    cfg_data (enabled)
//
// An item is taken when start is high and busy is low. Write, line and
// not-initialized items pass through accept and execute; an item that hands
// a byte to the transmitter passes through accept, execute, ring read and
// result. A host read gives each byte a registered ring read plus a result
// step, and one empty result when there is nothing to give. Results show
// for one cycle and cannot be held off. Reset leaves both rings empty and
// the port disabled; no clearing pass is needed. cfg_ready is high whenever
// the block is idle.
`default_nettype none

module uart_tx_rx_ring_buffers
    import urb_pkg::*;
#(
    parameter int DEPTH    = URB_DEPTH_DEF,
    parameter int MAX_READ = URB_MAX_READ_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic [BLEN_W-1:0]  burst_length,
    input  wire logic               burst_last,
    input  wire logic [LIMIT_W-1:0] read_limit,
    output logic                    result_valid,
    output logic [ST_W-1:0]         status,
    output logic [BYTE_W-1:0]       read_byte,
    output logic                    read_valid,
    output logic                    last,
    output logic                    tx_start,
    output logic [BYTE_W-1:0]       tx_byte,
    output logic                    overflow_seen,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data
);

    urb_cmd_t  cmd;
    urb_stat_t stat;

    // Register write transfer
    assign cfg_ready = !busy;

    urb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    urb_datapath #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .data_byte     (data_byte),
        .burst_length  (burst_length),
        .burst_last    (burst_last),
        .read_limit    (read_limit),
        .result_valid  (result_valid),
        .status        (status),
        .read_byte     (read_byte),
        .read_valid    (read_valid),
        .last          (last),
        .tx_start      (tx_start),
        .tx_byte       (tx_byte),
        .overflow_seen (overflow_seen)
    );

endmodule

`default_nettype wire

// ----- tb/uart_tx_rx_ring_buffers_tb.sv -----
// Self-checking testbench for uart_tx_rx_ring_buffers: directed table, then random traffic.
// A built-in port predictor checks every result. Depends on urb_pkg and the block's RTL.
`default_nettype none

module uart_tx_rx_ring_buffers_tb;
    import urb_pkg::*;

    localparam int DEPTH    = URB_DEPTH_DEF;
    localparam int MAX_READ = URB_MAX_READ_DEF;
    localparam int PTR_W    = $clog2(DEPTH);

    // One result transfer, field by field
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              last;
        logic              tx_start;
        logic [BYTE_W-1:0] tx_byte;
        logic              overflow_seen;
    } port_reply_t;

    // Directed stimulus row; a config row writes the enable register instead
    typedef struct {
        logic              is_cfg;
        logic              cfg_value;
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] din;
        logic [BLEN_W-1:0] blen;
        logic              blast;
        logic [LIMIT_W-1:0] limit;
        logic              typed;
        logic [ST_W-1:0]   exp_status;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    operation;
    logic [BYTE_W-1:0]  data_byte;
    logic [BLEN_W-1:0]  burst_length;
    logic               burst_last;
    logic [LIMIT_W-1:0] read_limit;
    logic               result_valid;
    logic [ST_W-1:0]    status;
    logic [BYTE_W-1:0]  read_byte;
    logic               read_valid;
    logic               last;
    logic               tx_start;
    logic [BYTE_W-1:0]  tx_byte;
    logic               overflow_seen;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    // Hand-typed status that rides along with a directed item
    logic               item_typed;
    logic [ST_W-1:0]    item_status;
    logic               pinned_on;
    logic [ST_W-1:0]    pinned_status;

    // Predicted port state
    logic [BYTE_W-1:0]  rx_ring [DEPTH];
    logic [BYTE_W-1:0]  tx_ring [DEPTH];
    logic [PTR_W-1:0]   rx_wr;
    logic [PTR_W-1:0]   rx_rd;
    logic [PTR_W-1:0]   tx_wr;
    logic [PTR_W-1:0]   tx_rd;
    logic               line_busy_m;
    logic               overflow_m;
    logic               burst_open_m;
    logic               burst_refused_m;
    logic [BLEN_W-1:0]  burst_left;
    logic               port_enabled;

    port_reply_t        pending_replies[$];
    stim_row_t          directed_rows[$];
    int                 fail_count;
    int                 items_sent;
    logic               steady;

    uart_tx_rx_ring_buffers u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .data_byte    (data_byte),
        .burst_length (burst_length),
        .burst_last   (burst_last),
        .read_limit   (read_limit),
        .result_valid (result_valid),
        .status       (status),
        .read_byte    (read_byte),
        .read_valid   (read_valid),
        .last         (last),
        .tx_start     (tx_start),
        .tx_byte      (tx_byte),
        .overflow_seen(overflow_seen),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #6000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Port predictor
    // ------------------------------------------------------------------
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (int'(p) + 1 >= DEPTH) ? '0 : p + 1'b1;
    endfunction

    function automatic int tx_free();
        int used;
        used = (tx_wr >= tx_rd) ? int'(tx_wr) - int'(tx_rd)
                                : DEPTH - (int'(tx_rd) - int'(tx_wr));
        return DEPTH - 1 - used;
    endfunction

    task automatic clear_port();
        rx_wr           = '0;
        rx_rd           = '0;
        tx_wr           = '0;
        tx_rd           = '0;
        line_busy_m     = 1'b0;
        overflow_m      = 1'b0;
        burst_open_m    = 1'b0;
        burst_refused_m = 1'b0;
        burst_left      = '0;
    endtask

    task automatic push_reply(input logic [ST_W-1:0] st, input logic [BYTE_W-1:0] rb,
                              input logic rv, input logic lst, input logic ts,
                              input logic [BYTE_W-1:0] tb);
        port_reply_t r;
        r.status        = pinned_on ? pinned_status : st;
        r.read_byte     = rb;
        r.read_valid    = rv;
        r.last          = lst;
        r.tx_start      = ts;
        r.tx_byte       = tb;
        r.overflow_seen = overflow_m;
        pending_replies.push_back(r);
    endtask

    // Advance the predicted port by one item and queue what it answers
    task automatic uart_port_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                                  input logic [BLEN_W-1:0] blen, input logic blast,
                                  input logic [LIMIT_W-1:0] limit);
        logic [ST_W-1:0]   st;
        logic              ts;
        logic [BYTE_W-1:0] tb;
        logic [PTR_W-1:0]  nxt;
        int                n;
        int                cnt;
        ts = 1'b0;
        tb = '0;
        if (op == OP_WRITE)
        begin
            // length check happens once, at the first byte of the burst
            if (!burst_open_m)
            begin
                burst_open_m = 1'b1;
                if (!port_enabled || int'(blen) > tx_free())
                begin
                    burst_refused_m = 1'b1;
                    burst_left      = '0;
                end
                else
                begin
                    burst_refused_m = 1'b0;
                    burst_left      = blen;
                end
            end
            if (burst_refused_m)
                st = port_enabled ? ST_FULL : ST_NOINIT;
            else
            begin
                st = ST_OK;
                if (burst_left != 0)
                begin
                    tx_ring[tx_wr] = din;
                    tx_wr          = ring_next(tx_wr);
                    burst_left     = burst_left - 1'b1;
                end
                if (blast && !line_busy_m && tx_rd != tx_wr)
                begin
                    line_busy_m = 1'b1;
                    ts          = 1'b1;
                    tb          = tx_ring[tx_rd];
                end
            end
            if (blast)
            begin
                burst_open_m    = 1'b0;
                burst_refused_m = 1'b0;
                burst_left      = '0;
            end
            push_reply(st, '0, 1'b0, 1'b1, ts, tb);
        end
        else if (!port_enabled)
            push_reply(ST_NOINIT, '0, 1'b0, 1'b1, 1'b0, '0);
        else if (op == OP_READ)
        begin
            n   = (int'(limit) > MAX_READ) ? MAX_READ : int'(limit);
            cnt = 0;
            while (cnt < n && rx_rd != rx_wr)
            begin
                nxt = ring_next(rx_rd);
                push_reply(ST_OK, rx_ring[rx_rd], 1'b1, (cnt + 1 == n) || (nxt == rx_wr),
                           1'b0, '0);
                rx_rd = nxt;
                cnt++;
            end
            if (cnt == 0)
                push_reply(ST_OK, '0, 1'b0, 1'b1, 1'b0, '0);
        end
        else if (op == OP_RX)
        begin
            nxt = ring_next(rx_wr);
            if (nxt == rx_rd)
                overflow_m = 1'b1;
            else
            begin
                rx_ring[rx_wr] = din;
                rx_wr          = nxt;
            end
            push_reply(ST_OK, '0, 1'b0, 1'b1, 1'b0, '0);
        end
        else
        begin
            // byte sent: retire the head, hand over the next one if any
            if (line_busy_m)
            begin
                if (tx_rd != tx_wr)
                    tx_rd = ring_next(tx_rd);
                if (tx_rd != tx_wr)
                begin
                    ts = 1'b1;
                    tb = tx_ring[tx_rd];
                end
                else
                    line_busy_m = 1'b0;
            end
            push_reply(ST_OK, '0, 1'b0, 1'b1, ts, tb);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check results, track config writes, predict accepted items
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        port_reply_t want;
        if (!rst_n)
        begin
            port_enabled = 1'b0;
            clear_port();
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_replies.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual status %0d byte %0d",
                             $time, status, read_byte);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", int'(want.status), int'(status));
                    check_field("read_byte", int'(want.read_byte), int'(read_byte));
                    check_field("read_valid", int'(want.read_valid), int'(read_valid));
                    check_field("last", int'(want.last), int'(last));
                    check_field("tx_start", int'(want.tx_start), int'(tx_start));
                    check_field("tx_byte", int'(want.tx_byte), int'(tx_byte));
                    check_field("overflow_seen", int'(want.overflow_seen),
                                int'(overflow_seen));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                port_enabled = cfg_data;
                clear_port();
            end
            if (start && !busy)
            begin
                pinned_on     = item_typed;
                pinned_status = item_status;
                uart_port_step(operation, data_byte, burst_length, burst_last, read_limit);
                pinned_on     = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Present one item and hold it until the block takes it
    task automatic issue(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                         input logic [BLEN_W-1:0] blen, input logic blast,
                         input logic [LIMIT_W-1:0] limit, input logic typed,
                         input logic [ST_W-1:0] exp_st);
        if (!steady && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        data_byte    <= din;
        burst_length <= blen;
        burst_last   <= blast;
        read_limit   <= limit;
        item_typed   <= typed;
        item_status  <= exp_st;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic push_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                             input logic [BLEN_W-1:0] blen, input logic blast,
                             input logic [LIMIT_W-1:0] limit);
        issue(op, din, blen, blast, limit, 1'b0, ST_OK);
    endtask

    // Enable register write, only once every result is in
    task automatic write_enable(input logic value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic is_cfg, input logic cfg_value, input logic [OP_W-1:0] op,
                           input logic [BYTE_W-1:0] din, input logic [BLEN_W-1:0] blen,
                           input logic blast, input logic [LIMIT_W-1:0] limit,
                           input logic typed, input logic [ST_W-1:0] exp_st);
        stim_row_t r;
        r = '{is_cfg, cfg_value, op, din, blen, blast, limit, typed, exp_st};
        directed_rows.push_back(r);
    endtask

    // Random items of one kind: received bytes, byte-sent notices or host reads
    task automatic line_events(input logic [OP_W-1:0] op, input int count);
        for (int i = 0; i < count; i++)
            push_item(op, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                      1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
    endtask

    // Write burst, mostly well formed, sometimes longer or shorter than declared
    task automatic random_burst();
        int declared;
        int count;
        logic blast;
        declared = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8);
        count    = declared;
        case ($urandom_range(0, 9))
            0: count = declared + $urandom_range(1, 3);
            1: if (declared > 1) count = $urandom_range(1, declared - 1);
            default: ;
        endcase
        if (count == 0)
            count = 1;
        if (count > 12)
            count = $urandom_range(1, 12);
        for (int i = 0; i < count; i++)
        begin
            blast = (i == count - 1);
            push_item(OP_WRITE, 8'($urandom_range(0, 255)),
                      (i == 0) ? 9'(declared) : 9'($urandom_range(0, 511)),
                      blast, 7'($urandom_range(0, 127)));
            // line traffic landing inside an open burst
            if (!blast && $urandom_range(0, 4) == 0)
                line_events($urandom_range(0, 1) ? OP_SENT : OP_RX, 1);
        end
    endtask

    task automatic random_traffic(input int count, input int calm_from, input int calm_to);
        int base;
        int pick;
        base = items_sent;
        while (items_sent - base < count)
        begin
            steady = (items_sent - base >= calm_from) && (items_sent - base < calm_to);
            pick   = $urandom_range(0, 99);
            if (pick < 35)
                random_burst();
            else if (pick < 58)
                line_events(OP_RX, $urandom_range(1, 4));
            else if (pick < 76)
                push_item(OP_READ, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                          1'($urandom_range(0, 1)),
                          ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 8))
                                                     : 7'($urandom_range(0, 127)));
            else
                line_events(OP_SENT, $urandom_range(1, 4));
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        int guard;
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_WRITE;
        data_byte    = '0;
        burst_length = '0;
        burst_last   = 1'b0;
        read_limit   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        item_typed   = 1'b0;
        item_status  = ST_OK;
        pinned_on    = 1'b0;
        pinned_status = ST_OK;
        fail_count   = 0;
        items_sent   = 0;
        steady       = 1'b0;

        //       cfg  val  op        data   blen    last lim     typed status
        // port disabled after reset: everything answers not initialized
        add_row(1'b0, 1'b0, OP_WRITE, 8'h00, 9'd1,   1'b1, 7'd0,   1'b1, ST_NOINIT);
        add_row(1'b0, 1'b0, OP_READ,  8'h00, 9'd0,   1'b0, 7'd64,  1'b1, ST_NOINIT);
        add_row(1'b0, 1'b0, OP_RX,    8'hFF, 9'd0,   1'b0, 7'd0,   1'b1, ST_NOINIT);
        add_row(1'b0, 1'b0, OP_SENT,  8'h00, 9'd0,   1'b0, 7'd0,   1'b1, ST_NOINIT);
        add_row(1'b1, 1'b1, OP_WRITE, 8'h00, 9'd0,   1'b0, 7'd0,   1'b0, ST_OK);
        // an empty read, two received bytes, then a clipped read limit
        add_row(1'b0, 1'b0, OP_READ,  8'h00, 9'd0,   1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_RX,    8'hFF, 9'd0,   1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_RX,    8'h00, 9'd511, 1'b1, 7'd127, 1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_READ,  8'h00, 9'd0,   1'b0, 7'd127, 1'b0, ST_OK);
        add_row(1'b0, 1'b0, OP_READ,  8'h00, 9'd0,   1'b0, 7'd1,   1'b1, ST_OK);
        // zero-length burst, then a three-byte burst with a stray sent notice
        add_row(1'b0, 1'b0, OP_WRITE, 8'h00, 9'd0,   1'b1, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_WRITE, 8'hA5, 9'd3,   1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_WRITE, 8'h5A, 9'h155, 1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_SENT,  8'h00, 9'd0,   1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_WRITE, 8'h01, 9'd0,   1'b1, 7'd0,   1'b0, ST_OK);
        add_row(1'b0, 1'b0, OP_SENT,  8'h00, 9'd0,   1'b0, 7'd0,   1'b0, ST_OK);
        // declared length larger than free space: whole burst refused
        add_row(1'b0, 1'b0, OP_WRITE, 8'h80, 9'd511, 1'b0, 7'd0,   1'b1, ST_FULL);
        add_row(1'b0, 1'b0, OP_WRITE, 8'h7F, 9'd0,   1'b1, 7'd0,   1'b1, ST_FULL);
        add_row(1'b0, 1'b0, OP_SENT,  8'h00, 9'd0,   1'b0, 7'd0,   1'b0, ST_OK);
        add_row(1'b0, 1'b0, OP_SENT,  8'h00, 9'd0,   1'b0, 7'd0,   1'b0, ST_OK);
        // full-size declaration fits an empty ring; burst ends short
        add_row(1'b0, 1'b0, OP_WRITE, 8'h80, 9'd511, 1'b1, 7'd0,   1'b1, ST_OK);
        // burst longer than declared while the line is busy
        add_row(1'b0, 1'b0, OP_WRITE, 8'h11, 9'd1,   1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_WRITE, 8'h22, 9'd0,   1'b0, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_WRITE, 8'h33, 9'd0,   1'b1, 7'd0,   1'b1, ST_OK);
        add_row(1'b0, 1'b0, OP_SENT,  8'h00, 9'd0,   1'b0, 7'd0,   1'b0, ST_OK);
        add_row(1'b1, 1'b0, OP_WRITE, 8'h00, 9'd0,   1'b0, 7'd0,   1'b0, ST_OK);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_enable(directed_rows[i].cfg_value);
            else
                issue(directed_rows[i].op, directed_rows[i].din, directed_rows[i].blen,
                      directed_rows[i].blast, directed_rows[i].limit,
                      directed_rows[i].typed, directed_rows[i].exp_status);
        end

        // disabled port: refusals and ignored line events
        random_traffic(40, 0, 0);
        write_enable(1'b1);
        random_traffic(270, 100, 200);
        // rewrite while already enabled: rings and flags cleared
        write_enable(1'b1);
        random_traffic(60, 0, 0);

        // short receive run and a burst, then full-size reads
        write_enable(1'b1);
        line_events(OP_RX, 8);
        random_burst();
        for (int i = 0; i < 2; i++)
            push_item(OP_READ, 8'h00, 9'd0, 1'b0, 7'(MAX_READ));
        write_enable(1'b0);
        line_events(OP_READ, 2);

        // drain
        start <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (pending_replies.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- uart_tx_rx_ring_buffers.f -----
rtl/urb_pkg.sv
rtl/urb_ram.sv
rtl/urb_ctrl.sv
rtl/urb_datapath.sv
rtl/uart_tx_rx_ring_buffers.sv
tb/uart_tx_rx_ring_buffers_tb.sv
